// ===== design/dsctw_pkg.sv =====
`timescale 1ns / 1ps

package dsctw_pkg;

   localparam int CHAIN_POS = 2;
   localparam int TAGRD_POS = 8;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TAG   = 1'b1;

   localparam logic [1:0] KIND_XFER  = 2'd0;
   localparam logic [1:0] KIND_FETCH = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   localparam logic [2:0] TAG_REFE = 3'd0;
   localparam logic [2:0] TAG_CNT  = 3'd1;
   localparam logic [2:0] TAG_NEXT = 3'd2;
   localparam logic [2:0] TAG_REF  = 3'd3;
   localparam logic [2:0] TAG_REFS = 3'd4;
   localparam logic [2:0] TAG_CALL = 3'd5;
   localparam logic [2:0] TAG_RET  = 3'd6;
   localparam logic [2:0] TAG_END  = 3'd7;

   localparam logic [1:0] DEPTH_ZERO = 2'd0;
   localparam logic [1:0] DEPTH_ONE  = 2'd1;
   localparam logic [1:0] DEPTH_TWO  = 2'd2;

   localparam logic [31:0] TAG_STRIDE = 32'd16;

   typedef struct packed {
      logic        func;
      logic [31:0] ctrl_in;
      logic [31:0] mem_addr_in;
      logic [15:0] qword_count_in;
      logic [31:0] tag_addr_in;
      logic [31:0] tag_word_low;
      logic [31:0] tag_word_high;
   } req_type;

   typedef struct packed {
      logic [31:0] ctrl;
      logic [31:0] tag_addr;
      logic [1:0]  depth;
   } chan_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] req_addr;
      logic [15:0] req_count;
      logic        irq_flag;
      logic        chain_error;
      logic [31:0] ctrl_out;
      logic [31:0] tag_addr_out;
      logic        last;
   } result_type;

   typedef struct packed {
      logic        wr_first;
      logic        wr_second;
      logic [31:0] ret_addr;
   } stack_wr_type;

endpackage

// ===== design/dsctw_step.sv =====
`timescale 1ns / 1ps

module dsctw_step (
   input  dsctw_pkg::req_type      item,
   input  dsctw_pkg::chan_type     cur,
   input  logic [31:0]             ret_first,
   input  logic [31:0]             ret_second,
   output dsctw_pkg::chan_type     nxt,
   output dsctw_pkg::stack_wr_type stack_wr,
   output logic [1:0]              n_results,
   output dsctw_pkg::result_type   res0,
   output dsctw_pkg::result_type   res1
);
   import dsctw_pkg::*;

   logic [31:0] mem_addr;
   logic [15:0] qw_count;
   logic [31:0] cnt_offset;
   logic [31:0] next_tag;
   logic [2:0]  tag_id;
   logic        irq;
   logic        err;

   function automatic result_type make_res(input logic [1:0] kind, input logic [31:0] addr,
                                           input logic [15:0] cnt, input logic irq_bit,
                                           input logic err_bit, input logic last_bit);
      result_type r;
      r              = '0;
      r.kind         = kind;
      r.req_addr     = addr;
      r.req_count    = cnt;
      r.irq_flag     = irq_bit;
      r.chain_error  = err_bit;
      r.last         = last_bit;
      return r;
   endfunction

   always_comb begin
      nxt       = cur;
      stack_wr  = '0;
      n_results = 2'd0;
      res0      = '0;
      res1      = '0;
      irq       = 1'b0;
      err       = 1'b0;
      tag_id    = item.tag_word_low[30:28];
      qw_count  = item.tag_word_low[15:0];
      cnt_offset = {12'd0, qw_count, 4'd0};
      next_tag  = cur.tag_addr + TAG_STRIDE;
      mem_addr  = next_tag;
      stack_wr.ret_addr = next_tag + cnt_offset;

      if (item.func == FUNC_START) begin
         nxt.ctrl     = item.ctrl_in;
         nxt.tag_addr = item.tag_addr_in;
         nxt.depth    = DEPTH_ZERO;
         if (item.ctrl_in == 32'd0) begin
            res0      = make_res(KIND_DONE, 32'd0, 16'd0, 1'b0, 1'b0, 1'b1);
            n_results = 2'd1;
         end else if (item.ctrl_in[CHAIN_POS]) begin
            res0 = make_res(KIND_XFER, item.mem_addr_in, item.qword_count_in,
                            1'b0, 1'b0, 1'b0);
            if (item.ctrl_in[TAGRD_POS]) begin
               res1 = make_res(KIND_FETCH, item.tag_addr_in, 16'd0, 1'b0, 1'b0, 1'b1);
            end else begin
               res1 = make_res(KIND_DONE, 32'd0, 16'd0, 1'b0, 1'b0, 1'b1);
            end
            n_results = 2'd2;
         end else if (item.qword_count_in != 16'd0) begin
            res0 = make_res(KIND_XFER, item.mem_addr_in, item.qword_count_in,
                            1'b0, 1'b0, 1'b0);
            res1 = make_res(KIND_DONE, 32'd0, 16'd0, 1'b0, 1'b0, 1'b1);
            n_results = 2'd2;
         end else begin
            res0      = make_res(KIND_DONE, 32'd0, 16'd0, 1'b0, 1'b0, 1'b1);
            n_results = 2'd1;
         end
      end else if (cur.ctrl[CHAIN_POS] && cur.ctrl[TAGRD_POS]) begin
         irq      = item.tag_word_low[31];
         nxt.ctrl = {item.tag_word_low[31:16], cur.ctrl[15:0]};
         case (tag_id)
            TAG_REFE: begin
               mem_addr = item.tag_word_high;
               nxt.ctrl[TAGRD_POS] = 1'b0;
            end
            TAG_CNT: begin
               nxt.tag_addr = next_tag + cnt_offset;
            end
            TAG_NEXT: begin
               nxt.tag_addr = item.tag_word_high;
            end
            TAG_REF, TAG_REFS: begin
               mem_addr     = item.tag_word_high;
               nxt.tag_addr = next_tag;
            end
            TAG_CALL: begin
               if (cur.depth == DEPTH_ZERO) begin
                  stack_wr.wr_first = 1'b1;
                  nxt.depth         = DEPTH_ONE;
               end else begin
                  stack_wr.wr_second = 1'b1;
                  nxt.depth          = DEPTH_TWO;
               end
               nxt.tag_addr = item.tag_word_high;
            end
            TAG_RET: begin
               if (cur.depth == DEPTH_ZERO) begin
                  err = 1'b1;
                  nxt.ctrl[TAGRD_POS] = 1'b0;
               end else if (cur.depth == DEPTH_ONE) begin
                  nxt.tag_addr = ret_first;
                  nxt.depth    = DEPTH_ZERO;
               end else begin
                  nxt.tag_addr = ret_second;
                  nxt.depth    = DEPTH_ONE;
               end
            end
            default: begin
               nxt.ctrl[TAGRD_POS] = 1'b0;
            end
         endcase

         if (qw_count != 16'd0) begin
            res0 = make_res(KIND_XFER, mem_addr, qw_count, irq, err, 1'b0);
            if (nxt.ctrl[TAGRD_POS]) begin
               res1 = make_res(KIND_FETCH, nxt.tag_addr, 16'd0, irq, err, 1'b1);
            end else begin
               res1 = make_res(KIND_DONE, 32'd0, 16'd0, irq, err, 1'b1);
            end
            n_results = 2'd2;
         end else begin
            if (nxt.ctrl[TAGRD_POS]) begin
               res0 = make_res(KIND_FETCH, nxt.tag_addr, 16'd0, irq, err, 1'b1);
            end else begin
               res0 = make_res(KIND_DONE, 32'd0, 16'd0, irq, err, 1'b1);
            end
            n_results = 2'd1;
         end
      end

      res0.ctrl_out     = nxt.ctrl;
      res0.tag_addr_out = nxt.tag_addr;
      res1.ctrl_out     = nxt.ctrl;
      res1.tag_addr_out = nxt.tag_addr;
   end

endmodule

// ===== design/dma_source_chain_tag_walker.sv =====
`timescale 1ns / 1ps

// channel  direction  handshake              payload
// req      in         req_valid / req_ready  func, control, addresses, count, tag words
// rsp      out        rsp_valid / rsp_ready  kind, address, count, flags, control, tag address
//
// A request is registered, decoded in the next cycle and its one or two responses are
// loaded into a two-entry response buffer when it has room; the port shows its head entry.
// One request per cycle is taken while the buffer has room; sustained rate is set by the
// response port, one response per cycle while rsp_ready is high, and two responses use it in turn.
// A tag request that arrives while the chain is not reading tags gives no response.
// Reset clears the channel control, tag address, call depth and all valid state.

module dma_source_chain_tag_walker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [31:0] req_ctrl_in,
   input  logic [31:0] req_mem_addr_in,
   input  logic [15:0] req_qword_count_in,
   input  logic [31:0] req_tag_addr_in,
   input  logic [31:0] req_tag_word_low,
   input  logic [31:0] req_tag_word_high,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_req_addr,
   output logic [15:0] rsp_req_count,
   output logic        rsp_irq_flag,
   output logic        rsp_chain_error,
   output logic [31:0] rsp_ctrl_out,
   output logic [31:0] rsp_tag_addr_out,
   output logic        rsp_last
);
   import dsctw_pkg::*;

   logic         in_valid_ff;
   logic         in_valid_in;
   req_type      item_ff;
   chan_type     chan_ff;
   chan_type     chan_in;
   logic [31:0]  ret_first_ff;
   logic [31:0]  ret_second_ff;
   logic [1:0]   cnt_ff;
   logic [1:0]   cnt_in;
   result_type   slot0_ff;
   result_type   slot0_in;
   result_type   slot1_ff;
   result_type   slot1_in;
   stack_wr_type stack_wr;
   logic [1:0]   n_results;
   result_type   res0;
   result_type   res1;
   logic         load_ok;
   logic         move;
   logic         pop;

   dsctw_step u_step (
      .item       (item_ff),
      .cur        (chan_ff),
      .ret_first  (ret_first_ff),
      .ret_second (ret_second_ff),
      .nxt        (chan_in),
      .stack_wr   (stack_wr),
      .n_results  (n_results),
      .res0       (res0),
      .res1       (res1)
   );

   assign pop       = rsp_valid && rsp_ready;
   assign load_ok   = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);
   assign move      = in_valid_ff && load_ok;
   assign req_ready = !in_valid_ff || move;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
      if (move && (n_results != 2'd0)) begin
         cnt_in   = n_results;
         slot0_in = res0;
         slot1_in = res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cnt_ff      <= 2'd0;
         chan_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         cnt_ff      <= cnt_in;
         if (move) begin
            chan_ff <= chan_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.func           <= req_func;
         item_ff.ctrl_in        <= req_ctrl_in;
         item_ff.mem_addr_in    <= req_mem_addr_in;
         item_ff.qword_count_in <= req_qword_count_in;
         item_ff.tag_addr_in    <= req_tag_addr_in;
         item_ff.tag_word_low   <= req_tag_word_low;
         item_ff.tag_word_high  <= req_tag_word_high;
      end
      if (move && stack_wr.wr_first) begin
         ret_first_ff <= stack_wr.ret_addr;
      end
      if (move && stack_wr.wr_second) begin
         ret_second_ff <= stack_wr.ret_addr;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_valid        = (cnt_ff != 2'd0);
   assign rsp_kind         = slot0_ff.kind;
   assign rsp_req_addr     = slot0_ff.req_addr;
   assign rsp_req_count    = slot0_ff.req_count;
   assign rsp_irq_flag     = slot0_ff.irq_flag;
   assign rsp_chain_error  = slot0_ff.chain_error;
   assign rsp_ctrl_out     = slot0_ff.ctrl_out;
   assign rsp_tag_addr_out = slot0_ff.tag_addr_out;
   assign rsp_last         = slot0_ff.last;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("response buffer count out of range");

   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      chan_ff.depth != 2'd3)
      else $error("call depth out of range");

   a_first_is_xfer: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_kind == KIND_XFER))
      else $error("non-final response is not a transfer");

   a_fetch_reads: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_FETCH)) |-> rsp_ctrl_out[TAGRD_POS])
      else $error("tag fetch with tag read bit clear");

   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_DONE)) |-> (rsp_req_addr == 32'd0 && rsp_last))
      else $error("malformed done response");

endmodule

// ===== dv/dma_source_chain_tag_walker_test.sv =====
`timescale 1ns / 1ps

module dma_source_chain_tag_walker_test;
   import dsctw_pkg::*;

   localparam int REQUEST_TARGET = 1550;
   localparam int PREDICTED = -1;
   localparam int DIR_ROWS = 24;
   localparam result_type NO_RSP = '0;

   typedef struct {
      req_type    req;
      int         n_rsp;
      result_type rsp [2];
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = 1'b0;
   logic [31:0] req_ctrl_in = '0;
   logic [31:0] req_mem_addr_in = '0;
   logic [15:0] req_qword_count_in = '0;
   logic [31:0] req_tag_addr_in = '0;
   logic [31:0] req_tag_word_low = '0;
   logic [31:0] req_tag_word_high = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_req_addr;
   logic [15:0] rsp_req_count;
   logic        rsp_irq_flag;
   logic        rsp_chain_error;
   logic [31:0] rsp_ctrl_out;
   logic [31:0] rsp_tag_addr_out;
   logic        rsp_last;

   logic [31:0] chan_ctrl = '0;
   logic [31:0] chan_mem_addr = '0;
   logic [31:0] chan_tag_addr = '0;
   logic [15:0] chan_count = '0;
   logic [31:0] ret_first = '0;
   logic [31:0] ret_second = '0;
   logic [1:0]  chan_depth = DEPTH_ZERO;

   result_type  step_rsp [2];
   int          step_n;
   result_type  pending_rsp [$];
   result_type  unused_rsp [2];
   dir_row_type directed_rows [DIR_ROWS];

   int failures = 0;
   int requests_taken = 0;
   int requests_useful = 0;
   int tags_ignored = 0;
   int responses_checked = 0;
   int underflows = 0;
   int drains = 0;
   int steady_left = 0;
   int ready_hold = 0;

   dma_source_chain_tag_walker uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_ctrl_in        (req_ctrl_in),
      .req_mem_addr_in    (req_mem_addr_in),
      .req_qword_count_in (req_qword_count_in),
      .req_tag_addr_in    (req_tag_addr_in),
      .req_tag_word_low   (req_tag_word_low),
      .req_tag_word_high  (req_tag_word_high),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_req_addr       (rsp_req_addr),
      .rsp_req_count      (rsp_req_count),
      .rsp_irq_flag       (rsp_irq_flag),
      .rsp_chain_error    (rsp_chain_error),
      .rsp_ctrl_out       (rsp_ctrl_out),
      .rsp_tag_addr_out   (rsp_tag_addr_out),
      .rsp_last           (rsp_last)
   );

   always #5 clock = ~clock;

   function automatic void add_result(input logic [1:0] kind, input logic [31:0] addr,
                                      input logic [15:0] count, input logic irq,
                                      input logic err, input logic last);
      step_rsp[step_n] = '{kind: kind, req_addr: addr, req_count: count, irq_flag: irq,
                           chain_error: err, ctrl_out: chan_ctrl,
                           tag_addr_out: chan_tag_addr, last: last};
      step_n++;
   endfunction

   function automatic void walk_request(input req_type r);
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] next_tag;
      logic        irq;
      logic        err;
      step_n = 0;
      if (r.func == FUNC_START) begin
         chan_ctrl = r.ctrl_in;
         chan_mem_addr = r.mem_addr_in;
         chan_count = r.qword_count_in;
         chan_tag_addr = r.tag_addr_in;
         chan_depth = DEPTH_ZERO;
         if (chan_ctrl == '0) begin
            add_result(KIND_DONE, '0, '0, 1'b0, 1'b0, 1'b1);
         end else if (chan_ctrl[CHAIN_POS]) begin
            add_result(KIND_XFER, chan_mem_addr, chan_count, 1'b0, 1'b0, 1'b0);
            if (chan_ctrl[TAGRD_POS])
               add_result(KIND_FETCH, chan_tag_addr, '0, 1'b0, 1'b0, 1'b1);
            else
               add_result(KIND_DONE, '0, '0, 1'b0, 1'b0, 1'b1);
         end else begin
            if (chan_count != '0)
               add_result(KIND_XFER, chan_mem_addr, chan_count, 1'b0, 1'b0, 1'b0);
            add_result(KIND_DONE, '0, '0, 1'b0, 1'b0, 1'b1);
         end
         return;
      end
      if (!chan_ctrl[CHAIN_POS] || !chan_ctrl[TAGRD_POS])
         return;
      lo = r.tag_word_low;
      hi = r.tag_word_high;
      irq = lo[31];
      err = 1'b0;
      next_tag = chan_tag_addr + TAG_STRIDE;
      chan_count = lo[15:0];
      chan_ctrl = {lo[31:16], chan_ctrl[15:0]};
      case (lo[30:28])
         TAG_REFE: begin
            chan_mem_addr = hi;
            chan_ctrl[TAGRD_POS] = 1'b0;
         end
         TAG_CNT: begin
            chan_mem_addr = next_tag;
            chan_tag_addr = next_tag + {12'd0, chan_count, 4'd0};
         end
         TAG_NEXT: begin
            chan_mem_addr = next_tag;
            chan_tag_addr = hi;
         end
         TAG_REF, TAG_REFS: begin
            chan_mem_addr = hi;
            chan_tag_addr = next_tag;
         end
         TAG_CALL: begin
            chan_mem_addr = next_tag;
            if (chan_depth == DEPTH_ZERO) begin
               ret_first = chan_mem_addr + {12'd0, chan_count, 4'd0};
               chan_depth = DEPTH_ONE;
            end else begin
               ret_second = chan_mem_addr + {12'd0, chan_count, 4'd0};
               chan_depth = DEPTH_TWO;
            end
            chan_tag_addr = hi;
         end
         TAG_RET: begin
            chan_mem_addr = next_tag;
            if (chan_depth == DEPTH_ZERO) begin
               err = 1'b1;
               chan_ctrl[TAGRD_POS] = 1'b0;
               underflows++;
            end else if (chan_depth == DEPTH_ONE) begin
               chan_tag_addr = ret_first;
               chan_depth = DEPTH_ZERO;
            end else begin
               chan_tag_addr = ret_second;
               chan_depth = DEPTH_ONE;
            end
         end
         default: begin
            chan_mem_addr = next_tag;
            chan_ctrl[TAGRD_POS] = 1'b0;
         end
      endcase
      if (chan_count != '0)
         add_result(KIND_XFER, chan_mem_addr, chan_count, irq, err, 1'b0);
      if (chan_ctrl[TAGRD_POS])
         add_result(KIND_FETCH, chan_tag_addr, '0, irq, err, 1'b1);
      else
         add_result(KIND_DONE, '0, '0, irq, err, 1'b1);
   endfunction

   function automatic req_type start_req(input logic [31:0] ctrl, input logic [31:0] mem,
                                         input logic [15:0] count, input logic [31:0] tag);
      return '{func: FUNC_START, ctrl_in: ctrl, mem_addr_in: mem, qword_count_in: count,
               tag_addr_in: tag, tag_word_low: $urandom, tag_word_high: $urandom};
   endfunction

   function automatic req_type tag_req(input logic [31:0] lo, input logic [31:0] hi);
      return '{func: FUNC_TAG, ctrl_in: $urandom, mem_addr_in: $urandom,
               qword_count_in: 16'($urandom), tag_addr_in: $urandom,
               tag_word_low: lo, tag_word_high: hi};
   endfunction

   function automatic result_type make_rsp(input logic [1:0] kind, input logic [31:0] addr,
                                           input logic [15:0] count, input logic irq,
                                           input logic err, input logic [31:0] ctrl,
                                           input logic [31:0] tag, input logic last);
      return '{kind: kind, req_addr: addr, req_count: count, irq_flag: irq,
               chain_error: err, ctrl_out: ctrl, tag_addr_out: tag, last: last};
   endfunction

   function automatic logic [15:0] random_count();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic req_type random_tag();
      int          sel;
      logic [2:0]  id;
      logic [31:0] lo;
      sel = $urandom_range(0, 11);
      if (sel < 8)
         id = 3'(sel);
      else if (sel < 10)
         id = TAG_CALL;
      else if (sel == 10)
         id = TAG_RET;
      else
         id = TAG_NEXT;
      lo = $urandom;
      lo[30:28] = id;
      lo[15:0] = random_count();
      return tag_req(lo, $urandom);
   endfunction

   function automatic int pick_gap();
      int r;
      if (steady_left > 0) begin
         steady_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         steady_left = $urandom_range(30, 80);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // enter and leave at a falling edge
   task automatic send_request(input req_type r, input int n_typed, input result_type typed [2]);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= r.func;
      req_ctrl_in <= r.ctrl_in;
      req_mem_addr_in <= r.mem_addr_in;
      req_qword_count_in <= r.qword_count_in;
      req_tag_addr_in <= r.tag_addr_in;
      req_tag_word_low <= r.tag_word_low;
      req_tag_word_high <= r.tag_word_high;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      walk_request(r);
      requests_taken++;
      if (step_n == 0)
         tags_ignored++;
      else
         requests_useful++;
      if (n_typed == PREDICTED) begin
         for (int i = 0; i < step_n; i++) pending_rsp.push_back(step_rsp[i]);
      end else begin
         for (int i = 0; i < n_typed; i++) pending_rsp.push_back(typed[i]);
      end
      @(negedge clock);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_rsp.size() != 0);
      drains++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         failures++;
      end
   endtask

   always @(negedge clock) begin
      if (ready_hold > 0) begin
         ready_hold--;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               rsp_ready <= 1'b1;
               ready_hold = $urandom_range(0, 24);
            end
            6, 7, 8: begin
               rsp_ready <= 1'b0;
               ready_hold = $urandom_range(0, 3);
            end
            default: begin
               rsp_ready <= 1'b0;
               ready_hold = $urandom_range(10, 40);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response: kind %0d addr 0x%0h", rsp_kind, rsp_req_addr);
            failures++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_kind));
            check_field("req_addr", want.req_addr, rsp_req_addr);
            check_field("req_count", 32'(want.req_count), 32'(rsp_req_count));
            check_field("irq_flag", 32'(want.irq_flag), 32'(rsp_irq_flag));
            check_field("chain_error", 32'(want.chain_error), 32'(rsp_chain_error));
            check_field("ctrl_out", want.ctrl_out, rsp_ctrl_out);
            check_field("tag_addr_out", want.tag_addr_out, rsp_tag_addr_out);
            check_field("last", 32'(want.last), 32'(rsp_last));
            responses_checked++;
         end
      end
   end

   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      req_type     r;
      logic [31:0] ctrl;
      int          sel;
      int          tag_run;
      unused_rsp = '{NO_RSP, NO_RSP};
      directed_rows = '{
         '{start_req(32'h0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF), 1,
           '{make_rsp(KIND_DONE, 32'h0, 16'h0, 1'b0, 1'b0, 32'h0, 32'hFFFF_FFFF, 1'b1),
             NO_RSP}},
         '{tag_req(32'hFFFF_FFFF, 32'hFFFF_FFFF), 0, '{NO_RSP, NO_RSP}},
         '{start_req(32'h1, 32'h1234_5678, 16'h0, 32'h0), 1,
           '{make_rsp(KIND_DONE, 32'h0, 16'h0, 1'b0, 1'b0, 32'h1, 32'h0, 1'b1), NO_RSP}},
         '{start_req(32'hFFFF_FFFB, 32'hFFFF_FFFF, 16'hFFFF, 32'hA5A5_A5A0), 2,
           '{make_rsp(KIND_XFER, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0, 32'hFFFF_FFFB,
                      32'hA5A5_A5A0, 1'b0),
             make_rsp(KIND_DONE, 32'h0, 16'h0, 1'b0, 1'b0, 32'hFFFF_FFFB,
                      32'hA5A5_A5A0, 1'b1)}},
         '{tag_req(32'h1000_0004, 32'h0), 0, '{NO_RSP, NO_RSP}},
         '{start_req(32'h4, 32'h1000, 16'h10, 32'h2000), 2,
           '{make_rsp(KIND_XFER, 32'h1000, 16'h10, 1'b0, 1'b0, 32'h4, 32'h2000, 1'b0),
             make_rsp(KIND_DONE, 32'h0, 16'h0, 1'b0, 1'b0, 32'h4, 32'h2000, 1'b1)}},
         '{tag_req(32'h7000_0000, 32'h0), 0, '{NO_RSP, NO_RSP}},
         '{start_req(32'h104, 32'h1000, 16'h0, 32'h2000), 2,
           '{make_rsp(KIND_XFER, 32'h1000, 16'h0, 1'b0, 1'b0, 32'h104, 32'h2000, 1'b0),
             make_rsp(KIND_FETCH, 32'h2000, 16'h0, 1'b0, 1'b0, 32'h104, 32'h2000, 1'b1)}},
         '{tag_req(32'h1000_0003, 32'hDEAD_BEEF), PREDICTED, '{NO_RSP, NO_RSP}},
         '{tag_req(32'h2000_0000, 32'h0000_3000), PREDICTED, '{NO_RSP, NO_RSP}},
         '{tag_req(32'h5000_0002, 32'h0000_4000), PREDICTED, '{NO_RSP, NO_RSP}},
         '{tag_req(32'hD000_0000, 32'h0000_5000), PREDICTED, '{NO_RSP, NO_RSP}},
         '{tag_req(32'h5000_0001, 32'h0000_6000), PREDICTED, '{NO_RSP, NO_RSP}},
         '{tag_req(32'h6000_0000, 32'hFFFF_FFFF), PREDICTED, '{NO_RSP, NO_RSP}},
         '{tag_req(32'h6000_0005, 32'h0), PREDICTED, '{NO_RSP, NO_RSP}},
         '{tag_req(32'hE000_0000, 32'h0), PREDICTED, '{NO_RSP, NO_RSP}},
         '{tag_req(32'h1000_0001, 32'h0), 0, '{NO_RSP, NO_RSP}},
         '{start_req(32'hFFFF_FFFF, 32'hFFFF_FFF0, 16'hFFFF, 32'hFFFF_FFF0), 2,
           '{make_rsp(KIND_XFER, 32'hFFFF_FFF0, 16'hFFFF, 1'b0, 1'b0, 32'hFFFF_FFFF,
                      32'hFFFF_FFF0, 1'b0),
             make_rsp(KIND_FETCH, 32'hFFFF_FFF0, 16'h0, 1'b0, 1'b0, 32'hFFFF_FFFF,
                      32'hFFFF_FFF0, 1'b1)}},
         '{tag_req(32'hB000_FFFF, 32'hFFFF_FFFF), PREDICTED, '{NO_RSP, NO_RSP}},
         '{tag_req(32'h4FFF_0000, 32'h0), PREDICTED, '{NO_RSP, NO_RSP}},
         '{tag_req(32'h1000_FFFF, 32'h0), PREDICTED, '{NO_RSP, NO_RSP}},
         '{tag_req(32'h0000_0007, 32'h8000_0000), PREDICTED, '{NO_RSP, NO_RSP}},
         '{start_req(32'h104, 32'h0, 16'h1, 32'h100), PREDICTED, '{NO_RSP, NO_RSP}},
         '{tag_req(32'hF123_4567, 32'h0), PREDICTED, '{NO_RSP, NO_RSP}}
      };

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].n_rsp, directed_rows[i].rsp);

      while (requests_taken < REQUEST_TARGET) begin
         if ($urandom_range(0, 39) == 0 || (drains == 0 && requests_useful > REQUEST_TARGET / 2))
            drain_responses();
         sel = $urandom_range(0, 19);
         ctrl = $urandom;
         if (sel == 0) begin
            ctrl = '0;
         end else if (sel < 3) begin
            ctrl[CHAIN_POS] = 1'b0;
            if (ctrl == '0) ctrl = 32'h1;
         end else if (sel < 5) begin
            ctrl[CHAIN_POS] = 1'b1;
            ctrl[TAGRD_POS] = 1'b0;
         end else begin
            ctrl[CHAIN_POS] = 1'b1;
            ctrl[TAGRD_POS] = 1'b1;
         end
         r = start_req(ctrl, $urandom, random_count(), $urandom);
         send_request(r, PREDICTED, unused_rsp);
         tag_run = $urandom_range(1, 12);
         // stop the chain early now and then; the next start breaks it off
         for (int i = 0; i < tag_run && chan_ctrl[CHAIN_POS] && chan_ctrl[TAGRD_POS]; i++)
            send_request(random_tag(), PREDICTED, unused_rsp);
         if ($urandom_range(0, 9) == 0)
            send_request(random_tag(), PREDICTED, unused_rsp);
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (pending_rsp.size() != 0);
      repeat (10) @(negedge clock);

      $display("Run covered %0d requests (%0d tags dropped while idle), %0d responses checked,",
               requests_taken, tags_ignored, responses_checked);
      $display("%0d return-stack underflows and %0d full drains of the response path.",
               underflows, drains);
      if (failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
